### design/assert_macros.svh
// Assertion macros shared by the RTL of the hex packing neighbor generator.
// Each check is sampled on clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HPNG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpng check failed");

// Next-cycle implication.
`define HPNG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpng check failed");

`endif

### design/hpng_pkg.sv
// Package for the hex packing neighbor generator: widths, register codes,
// neighbor categories, stage bundles and small helper functions. No dependencies.
package hpng_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 127;
  localparam int INDEX_BITS = 13;

  localparam int IDX_W     = INDEX_BITS;
  localparam int DIM_W     = 7;
  localparam int RAD_W     = 24;
  localparam int Q_W       = 32;
  localparam int CNT_W     = 3;
  localparam int NBR_N     = 6;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DIV_W  = $clog2(2 * MAX_COLS);
  localparam int PAIR_W = $clog2((MAX_ROWS + 1) / 2);
  localparam int ROW_W  = PAIR_W + 1;
  localparam int FAC_W  = COL_W + 1;
  localparam int TOT_W  = PAIR_W + DIV_W + 1;
  localparam int DR_W   = PAIR_W + DIV_W;
  localparam int REM_W  = (IDX_W > DR_W) ? IDX_W : DR_W;

  localparam int XP_W  = RAD_W + FAC_W;
  localparam int YP_W  = RAD_W + ROW_W;
  localparam int SQ_W  = 31;
  localparam int YM_W  = YP_W + SQ_W;
  localparam int FRAC  = 30;
  localparam int YO_W  = YM_W + 1 - FRAC;
  localparam int SUM_W = Q_W + 4;

  localparam logic [SQ_W-1:0] SQRT3_Q30 = SQ_W'(1859775393);

  // input register, one divider stage per quotient bit, decode, three arithmetic
  localparam int NSTAGE = PAIR_W + 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(4);

  localparam logic [DIM_W-1:0] RST_COLS   = DIM_W'(2);
  localparam logic [DIM_W-1:0] RST_ROWS   = DIM_W'(3);
  localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(65536);

  typedef enum logic [3:0] {
    CAT_TOP_L,
    CAT_TOP_R,
    CAT_TOP_E,
    CAT_BOT_L,
    CAT_BOT_R,
    CAT_BOT_E,
    CAT_WIDE_L,
    CAT_WIDE_R,
    CAT_SHORT_R,
    CAT_SHORT_ONE,
    CAT_SHORT_L,
    CAT_INNER
  } nbr_cat_t;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
    logic [FAC_W-1:0] fac;
  } geo_t;

  typedef logic [NBR_N-1:0][IDX_W-1:0] nbr_vec_t;

  function automatic logic [DIM_W-1:0] clamp_cols(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] v;
    v = raw;
    if (v < DIM_W'(2)) v = DIM_W'(2);
    if (v > DIM_W'(MAX_COLS)) v = DIM_W'(MAX_COLS);
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] fix_rows(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] v;
    v = raw;
    if (v < DIM_W'(3)) v = DIM_W'(3);
    if (v > DIM_W'(MAX_ROWS)) v = DIM_W'(MAX_ROWS);
    if (!v[0]) begin
      if (({1'b0, v} + (DIM_W + 1)'(1)) > (DIM_W + 1)'(MAX_ROWS)) v = v - DIM_W'(1);
      else v = v + DIM_W'(1);
    end
    return v;
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic in_range;
    in_range = (&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1]);
    if (in_range) return v[Q_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(Q_W - 1){1'b0}}};
    else return {1'b0, {(Q_W - 1){1'b1}}};
  endfunction

endpackage

### design/hpng_cfg.sv
// Configuration registers and the geometry values derived from them.
// Depends on hpng_pkg.
module hpng_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [hpng_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic [hpng_pkg::DIM_W-1:0]           n_cols,
  output logic [hpng_pkg::DIV_W-1:0]           pair_len,
  output logic [hpng_pkg::PAIR_W-1:0]          last_pair,
  output logic [hpng_pkg::TOT_W-1:0]           node_total,
  output logic [hpng_pkg::RAD_W-1:0]           radius,
  output logic signed [hpng_pkg::Q_W-1:0]      origin_x,
  output logic signed [hpng_pkg::Q_W-1:0]      origin_y
);

  logic [hpng_pkg::DIM_W-1:0]      cols_r, rows_r;
  logic [hpng_pkg::RAD_W-1:0]      radius_r;
  logic signed [hpng_pkg::Q_W-1:0] ox_r, oy_r;

  logic [hpng_pkg::DIM_W-1:0]  n_nxt, m_nxt, n_r;
  logic [hpng_pkg::DIV_W-1:0]  d_nxt, d_r;
  logic [hpng_pkg::PAIR_W-1:0] lastk_nxt, lastk_r;
  logic [hpng_pkg::TOT_W-1:0]  total_nxt, total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= hpng_pkg::RST_COLS;
      rows_r   <= hpng_pkg::RST_ROWS;
      radius_r <= hpng_pkg::RST_RADIUS;
      ox_r     <= '0;
      oy_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hpng_pkg::REG_NUM_COLS: cols_r   <= cfg_data[hpng_pkg::DIM_W-1:0];
        hpng_pkg::REG_NUM_ROWS: rows_r   <= cfg_data[hpng_pkg::DIM_W-1:0];
        hpng_pkg::REG_RADIUS:   radius_r <= cfg_data[hpng_pkg::RAD_W-1:0];
        hpng_pkg::REG_ORIGIN_X: ox_r     <= $signed(cfg_data[hpng_pkg::Q_W-1:0]);
        hpng_pkg::REG_ORIGIN_Y: oy_r     <= $signed(cfg_data[hpng_pkg::Q_W-1:0]);
        default: ;
      endcase
    end
  end

  // total = lastk*(2n-1) + n
  always_comb begin
    n_nxt     = hpng_pkg::clamp_cols(cols_r);
    m_nxt     = hpng_pkg::fix_rows(rows_r);
    d_nxt     = hpng_pkg::DIV_W'({n_nxt, 1'b0} - (hpng_pkg::DIM_W + 1)'(1));
    lastk_nxt = hpng_pkg::PAIR_W'((m_nxt - hpng_pkg::DIM_W'(1)) >> 1);
    total_nxt = hpng_pkg::TOT_W'(hpng_pkg::TOT_W'(lastk_nxt) * hpng_pkg::TOT_W'(d_nxt))
              + hpng_pkg::TOT_W'(n_nxt);
  end

  // Derived values follow the registers in the next cycle.
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    lastk_r <= lastk_nxt;
    total_r <= total_nxt;
  end

  assign n_cols     = n_r;
  assign pair_len   = d_r;
  assign last_pair  = lastk_r;
  assign node_total = total_r;
  assign radius     = radius_r;
  assign origin_x   = ox_r;
  assign origin_y   = oy_r;

endmodule

### design/hpng_div.sv
// Pipelined restoring divider: node index by row-pair length, one quotient
// bit per stage, plus the range check. Depends on hpng_pkg.
module hpng_div (
  input  logic                                 clk,
  input  logic [hpng_pkg::PAIR_W-1:0]          adv,
  input  logic [hpng_pkg::IDX_W-1:0]           idx_in,
  input  logic [hpng_pkg::DIV_W-1:0]           pair_len,
  input  logic [hpng_pkg::TOT_W-1:0]           node_total,
  output logic [hpng_pkg::PAIR_W-1:0]          pair_q,
  output logic [hpng_pkg::DIV_W-1:0]           pair_rem,
  output logic [hpng_pkg::IDX_W-1:0]           idx_out,
  output logic                                 ok_out
);

  localparam int NS = hpng_pkg::PAIR_W;

  logic [hpng_pkg::REM_W-1:0]  rem_r [NS];
  logic [hpng_pkg::PAIR_W-1:0] q_r   [NS];
  logic [hpng_pkg::IDX_W-1:0]  idx_r [NS];
  logic                        ok_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [hpng_pkg::REM_W-1:0]  rem_in, dsh;
    logic [hpng_pkg::PAIR_W-1:0] q_in;
    logic [hpng_pkg::IDX_W-1:0]  idx_s;
    logic                        ok_in;
    logic                        ge;

    if (s == 0) begin : g_first
      assign rem_in = hpng_pkg::REM_W'(idx_in);
      assign q_in   = '0;
      assign idx_s  = idx_in;
      assign ok_in  = hpng_pkg::TOT_W'(idx_in) < node_total;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign idx_s  = idx_r[s-1];
      assign ok_in  = ok_r[s-1];
    end

    assign dsh = hpng_pkg::REM_W'(pair_len) << (NS - 1 - s);
    assign ge  = rem_in >= dsh;

    // quotient fits in PAIR_W bits for every index below the node total
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        rem_r[s] <= ge ? (rem_in - dsh) : rem_in;
        q_r[s]   <= hpng_pkg::PAIR_W'({q_in, ge});
        idx_r[s] <= idx_s;
        ok_r[s]  <= ok_in;
      end
    end
  end

  assign pair_q   = q_r[NS-1];
  assign pair_rem = hpng_pkg::DIV_W'(rem_r[NS-1]);
  assign idx_out  = idx_r[NS-1];
  assign ok_out   = ok_r[NS-1];

endmodule

### design/hpng_nbr.sv
// Position decode and neighbor list assembly, four stages: decode, slot
// build, two delay stages to line up with the centre math. Depends on hpng_pkg.
module hpng_nbr (
  input  logic                                 clk,
  input  logic [3:0]                           adv,
  input  logic [hpng_pkg::PAIR_W-1:0]          pair_q,
  input  logic [hpng_pkg::DIV_W-1:0]           pair_rem,
  input  logic [hpng_pkg::IDX_W-1:0]           idx,
  input  logic                                 ok,
  input  logic [hpng_pkg::DIM_W-1:0]           n_cols,
  input  logic [hpng_pkg::PAIR_W-1:0]          last_pair,
  output hpng_pkg::geo_t                       geo,
  output logic                                 ok_out,
  output logic [hpng_pkg::CNT_W-1:0]           nbr_cnt,
  output hpng_pkg::nbr_vec_t                   nbr_vec
);

  localparam int C_MN  = 0;  // i-n
  localparam int C_MN1 = 1;  // i-n+1
  localparam int C_P1  = 2;  // i+1
  localparam int C_PN  = 3;  // i+n
  localparam int C_PN1 = 4;  // i+n-1
  localparam int C_M1  = 5;  // i-1

  logic [hpng_pkg::DIV_W-1:0] n_d, col_w;
  logic [hpng_pkg::IDX_W-1:0] n_i;
  logic                       short_w, col_end, col_sl, k_top, k_bot;
  hpng_pkg::nbr_cat_t         cat_nxt, cat_r;
  hpng_pkg::nbr_vec_t         cand_nxt, cand_r;
  hpng_pkg::geo_t             geo_nxt, geo_r;

  hpng_pkg::nbr_vec_t         slot_nxt;
  logic [hpng_pkg::CNT_W-1:0] cnt_nxt;
  hpng_pkg::nbr_vec_t         slot_r [3];
  logic [hpng_pkg::CNT_W-1:0] cnt_r  [3];
  logic                       ok_r   [3];

  always_comb begin
    n_d     = hpng_pkg::DIV_W'(n_cols);
    n_i     = hpng_pkg::IDX_W'(n_cols);
    short_w = pair_rem >= n_d;
    col_w   = short_w ? (pair_rem - n_d) : pair_rem;
    col_end = col_w == (n_d - hpng_pkg::DIV_W'(1));
    col_sl  = col_w == (n_d - hpng_pkg::DIV_W'(2));
    k_top   = pair_q == '0;
    k_bot   = pair_q == last_pair;

    if (!short_w && k_top) begin
      if (col_w == '0) cat_nxt = hpng_pkg::CAT_TOP_L;
      else if (col_end) cat_nxt = hpng_pkg::CAT_TOP_R;
      else cat_nxt = hpng_pkg::CAT_TOP_E;
    end else if (!short_w && k_bot) begin
      if (col_w == '0) cat_nxt = hpng_pkg::CAT_BOT_L;
      else if (col_end) cat_nxt = hpng_pkg::CAT_BOT_R;
      else cat_nxt = hpng_pkg::CAT_BOT_E;
    end else if (!short_w && col_w == '0) begin
      cat_nxt = hpng_pkg::CAT_WIDE_L;
    end else if (!short_w && col_end) begin
      cat_nxt = hpng_pkg::CAT_WIDE_R;
    end else if (short_w && col_sl) begin
      // a one-circle short row sees i-1 twice; drop the second
      cat_nxt = (n_cols == hpng_pkg::DIM_W'(2)) ? hpng_pkg::CAT_SHORT_ONE
                                                : hpng_pkg::CAT_SHORT_R;
    end else if (short_w && col_w == '0) begin
      cat_nxt = hpng_pkg::CAT_SHORT_L;
    end else begin
      cat_nxt = hpng_pkg::CAT_INNER;
    end

    cand_nxt[C_MN]  = idx - n_i;
    cand_nxt[C_MN1] = idx - n_i + hpng_pkg::IDX_W'(1);
    cand_nxt[C_P1]  = idx + hpng_pkg::IDX_W'(1);
    cand_nxt[C_PN]  = idx + n_i;
    cand_nxt[C_PN1] = idx + n_i - hpng_pkg::IDX_W'(1);
    cand_nxt[C_M1]  = idx - hpng_pkg::IDX_W'(1);

    geo_nxt.ok  = ok;
    geo_nxt.row = {pair_q, short_w};
    geo_nxt.fac = {hpng_pkg::COL_W'(col_w), short_w};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cat_r  <= cat_nxt;
      cand_r <= cand_nxt;
      geo_r  <= geo_nxt;
    end
  end

  always_comb begin
    slot_nxt = '0;
    cnt_nxt  = '0;
    case (cat_r)
      hpng_pkg::CAT_TOP_L: begin
        slot_nxt[0] = cand_r[C_P1];  slot_nxt[1] = cand_r[C_PN];
        cnt_nxt = hpng_pkg::CNT_W'(2);
      end
      hpng_pkg::CAT_TOP_R: begin
        slot_nxt[0] = cand_r[C_PN1]; slot_nxt[1] = cand_r[C_M1];
        cnt_nxt = hpng_pkg::CNT_W'(2);
      end
      hpng_pkg::CAT_TOP_E: begin
        slot_nxt[0] = cand_r[C_P1];  slot_nxt[1] = cand_r[C_PN];
        slot_nxt[2] = cand_r[C_PN1]; slot_nxt[3] = cand_r[C_M1];
        cnt_nxt = hpng_pkg::CNT_W'(4);
      end
      hpng_pkg::CAT_BOT_L: begin
        slot_nxt[0] = cand_r[C_MN1]; slot_nxt[1] = cand_r[C_P1];
        cnt_nxt = hpng_pkg::CNT_W'(2);
      end
      hpng_pkg::CAT_BOT_R: begin
        slot_nxt[0] = cand_r[C_M1];  slot_nxt[1] = cand_r[C_MN];
        cnt_nxt = hpng_pkg::CNT_W'(2);
      end
      hpng_pkg::CAT_BOT_E: begin
        slot_nxt[0] = cand_r[C_M1];  slot_nxt[1] = cand_r[C_MN];
        slot_nxt[2] = cand_r[C_MN1]; slot_nxt[3] = cand_r[C_P1];
        cnt_nxt = hpng_pkg::CNT_W'(4);
      end
      hpng_pkg::CAT_WIDE_L: begin
        slot_nxt[0] = cand_r[C_MN1]; slot_nxt[1] = cand_r[C_P1];
        slot_nxt[2] = cand_r[C_PN];
        cnt_nxt = hpng_pkg::CNT_W'(3);
      end
      hpng_pkg::CAT_WIDE_R: begin
        slot_nxt[0] = cand_r[C_PN1]; slot_nxt[1] = cand_r[C_M1];
        slot_nxt[2] = cand_r[C_MN];
        cnt_nxt = hpng_pkg::CNT_W'(3);
      end
      hpng_pkg::CAT_SHORT_R: begin
        slot_nxt[0] = cand_r[C_PN];  slot_nxt[1] = cand_r[C_PN1];
        slot_nxt[2] = cand_r[C_M1];  slot_nxt[3] = cand_r[C_MN];
        slot_nxt[4] = cand_r[C_MN1];
        cnt_nxt = hpng_pkg::CNT_W'(5);
      end
      hpng_pkg::CAT_SHORT_ONE: begin
        slot_nxt[0] = cand_r[C_PN];  slot_nxt[1] = cand_r[C_PN1];
        slot_nxt[2] = cand_r[C_M1];  slot_nxt[3] = cand_r[C_MN];
        cnt_nxt = hpng_pkg::CNT_W'(4);
      end
      hpng_pkg::CAT_SHORT_L: begin
        slot_nxt[0] = cand_r[C_MN];  slot_nxt[1] = cand_r[C_MN1];
        slot_nxt[2] = cand_r[C_P1];  slot_nxt[3] = cand_r[C_PN];
        slot_nxt[4] = cand_r[C_PN1];
        cnt_nxt = hpng_pkg::CNT_W'(5);
      end
      hpng_pkg::CAT_INNER: begin
        slot_nxt = cand_r;
        cnt_nxt  = hpng_pkg::CNT_W'(6);
      end
      default: ;
    endcase
    if (!geo_r.ok) begin
      slot_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      slot_r[0] <= slot_nxt;
      cnt_r[0]  <= cnt_nxt;
      ok_r[0]   <= geo_r.ok;
    end
    if (adv[2]) begin
      slot_r[1] <= slot_r[0];
      cnt_r[1]  <= cnt_r[0];
      ok_r[1]   <= ok_r[0];
    end
    if (adv[3]) begin
      slot_r[2] <= slot_r[1];
      cnt_r[2]  <= cnt_r[1];
      ok_r[2]   <= ok_r[1];
    end
  end

  assign geo     = geo_r;
  assign ok_out  = ok_r[2];
  assign nbr_cnt = cnt_r[2];
  assign nbr_vec = slot_r[2];

endmodule

### design/hpng_geo.sv
// Circle centre arithmetic in three stages: radius products, x sum and
// sqrt(3) product, y rounding and sum. Depends on hpng_pkg.
module hpng_geo (
  input  logic                                 clk,
  input  logic [2:0]                           adv,
  input  hpng_pkg::geo_t                       geo,
  input  logic [hpng_pkg::RAD_W-1:0]           radius,
  input  logic signed [hpng_pkg::Q_W-1:0]      origin_x,
  input  logic signed [hpng_pkg::Q_W-1:0]      origin_y,
  output logic signed [hpng_pkg::Q_W-1:0]      centre_x,
  output logic signed [hpng_pkg::Q_W-1:0]      centre_y
);

  logic [hpng_pkg::XP_W-1:0]       xp_r;
  logic [hpng_pkg::YP_W-1:0]       yp_r;
  logic                            ok_a_r, ok_b_r;
  logic signed [hpng_pkg::Q_W-1:0] x_r;
  logic [hpng_pkg::YM_W-1:0]       ym_r;
  logic signed [hpng_pkg::Q_W-1:0] cx_r, cy_r;

  logic signed [hpng_pkg::SUM_W-1:0] xs, ys;
  logic [hpng_pkg::YM_W:0]           yrnd;
  logic [hpng_pkg::YO_W-1:0]         yoff;

  // Stage a: radius*(2*col + short) and radius*row.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xp_r   <= hpng_pkg::XP_W'(radius) * hpng_pkg::XP_W'(geo.fac);
      yp_r   <= hpng_pkg::YP_W'(radius) * hpng_pkg::YP_W'(geo.row);
      ok_a_r <= geo.ok;
    end
  end

  // Stage b: saturate x; scale row*radius by sqrt(3) in Q30.
  // row*radius stays below 2^32 for every legal row, so no clamp is needed.
  assign xs = hpng_pkg::SUM_W'(origin_x) + $signed(hpng_pkg::SUM_W'(xp_r));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x_r    <= hpng_pkg::sat_q(xs);
      ym_r   <= hpng_pkg::YM_W'(yp_r) * hpng_pkg::YM_W'(hpng_pkg::SQRT3_Q30);
      ok_b_r <= ok_a_r;
    end
  end

  // Stage c: round half up at the Q30 point, add origin, saturate.
  always_comb begin
    yrnd = (hpng_pkg::YM_W + 1)'(ym_r) + ((hpng_pkg::YM_W + 1)'(1) << (hpng_pkg::FRAC - 1));
    yoff = yrnd[hpng_pkg::YM_W:hpng_pkg::FRAC];
    ys   = hpng_pkg::SUM_W'(origin_y) + $signed(hpng_pkg::SUM_W'(yoff));
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cx_r <= ok_b_r ? x_r : '0;
      cy_r <= ok_b_r ? hpng_pkg::sat_q(ys) : '0;
    end
  end

  assign centre_x = cx_r;
  assign centre_y = cy_r;

endmodule

### design/hex_packing_neighbor_generator_core.sv
// Hex packing neighbor generator. For each node index word the block returns
// one result word: an index-valid flag, the neighbor count and up to six
// neighbor indices in fixed per-position order, and the circle centre in Q16.16.
//
// Channels: in_* takes node indices, out_* delivers results, cfg_* writes the
// five geometry registers (index 0..4; other indices are ignored). All use a
// valid/ready pair; cfg_ready is always high. Write configuration only while
// no words are in flight.
//
// From input accept to out_valid a word passes one input register,
// six divider stages (one quotient bit each for index / (2n-1)), a decode
// stage and three arithmetic stages where the sqrt(3) multiply sets the depth.
// Throughput is one word per cycle while out_ready stays high.
//
// Reset (rst_n low, synchronous) empties the pipeline and loads num_cols 2,
// num_rows 3, radius 1.0, origin (0, 0). When out_ready is low the output word
// holds; each stage keeps taking words until it holds one it cannot pass on,
// so empty slots fill first and in_ready drops only when all stages are full.
// Depends on hpng_pkg, hpng_cfg, hpng_div, hpng_nbr, hpng_geo, assert_macros.svh.
`include "assert_macros.svh"

module hex_packing_neighbor_generator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hpng_pkg::IDX_W-1:0]           in_node_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_index_valid,
  output logic [hpng_pkg::CNT_W-1:0]           out_neighbor_count,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_a,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_b,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_c,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_d,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_e,
  output logic [hpng_pkg::IDX_W-1:0]           out_neighbor_f,
  output logic signed [hpng_pkg::Q_W-1:0]      out_centre_x,
  output logic signed [hpng_pkg::Q_W-1:0]      out_centre_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hpng_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam int NS    = hpng_pkg::NSTAGE;
  localparam int DIV0  = 1;                          // first divider stage
  localparam int DEC   = hpng_pkg::PAIR_W + 1;       // decode stage
  localparam int ARI0  = DEC + 1;                    // first arithmetic stage

  // Config
  logic [hpng_pkg::DIM_W-1:0]      n_cols;
  logic [hpng_pkg::DIV_W-1:0]      pair_len;
  logic [hpng_pkg::PAIR_W-1:0]     last_pair;
  logic [hpng_pkg::TOT_W-1:0]      node_total;
  logic [hpng_pkg::RAD_W-1:0]      radius;
  logic signed [hpng_pkg::Q_W-1:0] origin_x, origin_y;

  // Pipeline control: one valid bit per stage, advance per stage
  logic [NS-1:0] st_v_r;
  logic [NS-1:0] v_in;
  logic [NS-1:0] adv;

  logic [hpng_pkg::IDX_W-1:0]  idx0_r;
  logic [hpng_pkg::PAIR_W-1:0] pair_q;
  logic [hpng_pkg::DIV_W-1:0]  pair_rem;
  logic [hpng_pkg::IDX_W-1:0]  div_idx;
  logic                        div_ok;
  hpng_pkg::geo_t              geo;
  logic                        nbr_ok;
  logic [hpng_pkg::CNT_W-1:0]  nbr_cnt;
  hpng_pkg::nbr_vec_t          nbr_vec;

  assign cfg_ready = 1'b1;

  hpng_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_cols     (n_cols),
    .pair_len   (pair_len),
    .last_pair  (last_pair),
    .node_total (node_total),
    .radius     (radius),
    .origin_x   (origin_x),
    .origin_y   (origin_y)
  );

  // A stage advances when it or any stage downstream of it is empty, or when
  // the receiver is ready; the last stage moves when the receiver takes the word.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = out_ready || !(&(st_v_r | NS'((1 << k) - 1)));
    end
  end

  assign v_in = {st_v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) st_v_r[k] <= v_in[k];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv[0]) idx0_r <= in_node_index;
  end

  hpng_div u_div (
    .clk        (clk),
    .adv        (adv[DEC-1:DIV0]),
    .idx_in     (idx0_r),
    .pair_len   (pair_len),
    .node_total (node_total),
    .pair_q     (pair_q),
    .pair_rem   (pair_rem),
    .idx_out    (div_idx),
    .ok_out     (div_ok)
  );

  hpng_nbr u_nbr (
    .clk       (clk),
    .adv       (adv[NS-1:DEC]),
    .pair_q    (pair_q),
    .pair_rem  (pair_rem),
    .idx       (div_idx),
    .ok        (div_ok),
    .n_cols    (n_cols),
    .last_pair (last_pair),
    .geo       (geo),
    .ok_out    (nbr_ok),
    .nbr_cnt   (nbr_cnt),
    .nbr_vec   (nbr_vec)
  );

  hpng_geo u_geo (
    .clk      (clk),
    .adv      (adv[NS-1:ARI0]),
    .geo      (geo),
    .radius   (radius),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .centre_x (out_centre_x),
    .centre_y (out_centre_y)
  );

  assign in_ready           = adv[0];
  assign out_valid          = st_v_r[NS-1];
  assign out_index_valid    = nbr_ok;
  assign out_neighbor_count = nbr_cnt;
  assign out_neighbor_a     = nbr_vec[0];
  assign out_neighbor_b     = nbr_vec[1];
  assign out_neighbor_c     = nbr_vec[2];
  assign out_neighbor_d     = nbr_vec[3];
  assign out_neighbor_e     = nbr_vec[4];
  assign out_neighbor_f     = nbr_vec[5];

  // Out-of-range index: the count and both centres must come out zero.
  `HPNG_ASSERT_IMP(a_invalid_zero, out_valid && !out_index_valid, out_neighbor_count == '0 && out_centre_x == '0 && out_centre_y == '0)
  // In-range index: two to six neighbors.
  `HPNG_ASSERT_IMP(a_count_range, out_valid && out_index_valid, out_neighbor_count >= 3'd2 && out_neighbor_count <= 3'd6)
  // The first two slots are always distinct neighbors.
  `HPNG_ASSERT_IMP(a_first_distinct, out_valid && out_index_valid, out_neighbor_a != out_neighbor_b)
  // A word never waits behind an empty stage.
  `HPNG_ASSERT_NXT(a_no_bubble_stall, st_v_r[0] && !st_v_r[1], st_v_r[1])

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for hex_packing_neighbor_generator_core: node index words are
// streamed under random back-pressure and every result word is checked against a local
// predictor of the packing. Depends on hpng_pkg and the core RTL.
module tb_top;
  import hpng_pkg::*;

  // Allow for the worst quiet stretch: a full sender gap, the pipeline depth, a full
  // receiver stall and the settle pause between geometry settings, with margin.
  localparam int QUIET_LIMIT = 1000;
  // Cycles to let pass after the last answer; the pipeline is 11 stages deep.
  localparam int DRAIN_PAD   = 16;
  localparam int PHASES      = 12;
  localparam int HALF_PHASE  = 70;

  // Register indexes the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  typedef struct packed {
    logic                    ok;
    logic [CNT_W-1:0]        cnt;
    nbr_vec_t                nb;
    logic signed [Q_W-1:0]   cx;
    logic signed [Q_W-1:0]   cy;
  } hex_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [IDX_W-1:0]            in_node_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_index_valid;
  logic [CNT_W-1:0]            out_neighbor_count;
  logic [IDX_W-1:0]            out_neighbor_a;
  logic [IDX_W-1:0]            out_neighbor_b;
  logic [IDX_W-1:0]            out_neighbor_c;
  logic [IDX_W-1:0]            out_neighbor_d;
  logic [IDX_W-1:0]            out_neighbor_e;
  logic [IDX_W-1:0]            out_neighbor_f;
  logic signed [Q_W-1:0]       out_centre_x;
  logic signed [Q_W-1:0]       out_centre_y;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_NUM_COLS;
  logic [31:0]                 cfg_data = '0;

  // Local copy of the geometry registers, updated on each accepted register write.
  logic [DIM_W-1:0]            cols_reg   = RST_COLS;
  logic [DIM_W-1:0]            rows_reg   = RST_ROWS;
  logic [RAD_W-1:0]            radius_reg = RST_RADIUS;
  logic signed [Q_W-1:0]       org_x      = '0;
  logic signed [Q_W-1:0]       org_y      = '0;

  logic [IDX_W-1:0]            node_queue[$];   // node words waiting to be sent
  hex_result_t                 answers_due[$];  // predicted answers, oldest first

  bit  calm = 1'b0;                             // no idling on either side when set
  int  send_gap = 0;
  int  hold_gap = 0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  words_sent = 0;
  int  answers_checked = 0;
  int  out_of_range_seen = 0;
  int  settings_used = 0;

  hex_packing_neighbor_generator_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_node_index      (in_node_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_index_valid    (out_index_valid),
    .out_neighbor_count (out_neighbor_count),
    .out_neighbor_a     (out_neighbor_a),
    .out_neighbor_b     (out_neighbor_b),
    .out_neighbor_c     (out_neighbor_c),
    .out_neighbor_d     (out_neighbor_d),
    .out_neighbor_e     (out_neighbor_e),
    .out_neighbor_f     (out_neighbor_f),
    .out_centre_x       (out_centre_x),
    .out_centre_y       (out_centre_y),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Effective packing size: clamp columns and rows, force the row count odd.
  function automatic void geometry_dims(output int n, output int m, output int total);
    n = int'(cols_reg);
    if (n < 2) n = 2;
    if (n > MAX_COLS) n = MAX_COLS;
    m = int'(rows_reg);
    if (m < 3) m = 3;
    if (m > MAX_ROWS) m = MAX_ROWS;
    if (m % 2 == 0) m = (m + 1 > MAX_ROWS) ? m - 1 : m + 1;
    total = ((m + 1) / 2) * n + ((m - 1) / 2) * (n - 1);
  endfunction

  function automatic logic signed [Q_W-1:0] clip_q(input longint v);
    if (v > 64'sd2147483647) return {1'b0, {(Q_W - 1){1'b1}}};
    if (v < -64'sd2147483648) return {1'b1, {(Q_W - 1){1'b0}}};
    return v[Q_W-1:0];
  endfunction

  // Neighbor list and centre of one node under the current geometry.
  function automatic hex_result_t predict_node(input logic [IDX_W-1:0] node);
    int n, m, total, i, pair, r, col, row, lastk, nc, kept;
    int cand[6];
    bit shortrow, dup;
    longint x, y;
    longint unsigned p, yoff;
    hex_result_t res;
    res = '0;
    geometry_dims(n, m, total);
    i = int'(node);
    if (i >= total) return res;

    pair     = i / (2 * n - 1);
    r        = i % (2 * n - 1);
    shortrow = (r >= n);
    col      = shortrow ? r - n : r;
    row      = shortrow ? 2 * pair + 1 : 2 * pair;
    lastk    = (m - 1) / 2;

    if (!shortrow && pair == 0) begin
      if (col == 0) begin
        cand = '{i + 1, i + n, 0, 0, 0, 0}; nc = 2;
      end else if (col == n - 1) begin
        cand = '{i + n - 1, i - 1, 0, 0, 0, 0}; nc = 2;
      end else begin
        cand = '{i + 1, i + n, i + n - 1, i - 1, 0, 0}; nc = 4;
      end
    end else if (!shortrow && pair == lastk) begin
      if (col == 0) begin
        cand = '{i - n + 1, i + 1, 0, 0, 0, 0}; nc = 2;
      end else if (col == n - 1) begin
        cand = '{i - 1, i - n, 0, 0, 0, 0}; nc = 2;
      end else begin
        cand = '{i - 1, i - n, i - n + 1, i + 1, 0, 0}; nc = 4;
      end
    end else if (!shortrow && col == 0) begin
      cand = '{i - n + 1, i + 1, i + n, 0, 0, 0}; nc = 3;
    end else if (!shortrow && col == n - 1) begin
      cand = '{i + n - 1, i - 1, i - n, 0, 0, 0}; nc = 3;
    end else if (shortrow && col == n - 2) begin
      // right end of a short row wins, so a one-node short row lands here
      cand = '{i + n, i + n - 1, i - 1, i - n, i - n + 1, 0}; nc = 5;
    end else if (shortrow && col == 0) begin
      cand = '{i - n, i - n + 1, i + 1, i + n, i + n - 1, 0}; nc = 5;
    end else begin
      cand = '{i - n, i - n + 1, i + 1, i + n, i + n - 1, i - 1}; nc = 6;
    end

    // drop any neighbor already listed
    kept = 0;
    for (int j = 0; j < nc; j++) begin
      dup = 1'b0;
      for (int q = 0; q < j; q++)
        if (cand[q] == cand[j]) dup = 1'b1;
      if (!dup) begin
        res.nb[kept] = IDX_W'(cand[j]);
        kept++;
      end
    end
    res.ok  = 1'b1;
    res.cnt = CNT_W'(kept);

    x = longint'(org_x) + longint'(radius_reg) * longint'(2 * col + (shortrow ? 1 : 0));
    res.cx = clip_q(x);

    p = longint'(row) * longint'(radius_reg);
    if (p >= 64'h1_0000_0000) yoff = 64'h2_0000_0000;
    else yoff = (p * 64'(SQRT3_Q30) + (64'd1 << 29)) >> 30;
    y = longint'(org_y) + longint'(yoff);
    res.cy = clip_q(y);
    return res;
  endfunction

  // Mostly in-range nodes, weighted toward row ends and the outer rows; some raw noise.
  function automatic logic [IDX_W-1:0] pick_node();
    int n, m, total, row, start, len, pos, sel;
    geometry_dims(n, m, total);
    sel = $urandom_range(0, 19);
    if (sel < 3) return IDX_W'($urandom());
    if (sel < 11) return IDX_W'($urandom_range(0, total - 1));
    case ($urandom_range(0, 2))
      0:       row = 0;
      1:       row = m - 1;
      default: row = $urandom_range(0, m - 1);
    endcase
    start = (row / 2) * (2 * n - 1) + ((row % 2 != 0) ? n : 0);
    len   = (row % 2 != 0) ? n - 1 : n;
    case ($urandom_range(0, 3))
      0:       pos = 0;
      1:       pos = len - 1;
      2:       pos = (len > 1) ? 1 : 0;
      default: pos = (len > 2) ? len - 2 : 0;
    endcase
    return IDX_W'(start + pos);
  endfunction

  // One register write; update the local copy at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_COLS: cols_reg   = data[DIM_W-1:0];
      REG_NUM_ROWS: rows_reg   = data[DIM_W-1:0];
      REG_RADIUS:   radius_reg = data[RAD_W-1:0];
      REG_ORIGIN_X: org_x      = data;
      REG_ORIGIN_Y: org_y      = data;
      default: ;
    endcase
  endtask

  task automatic load_geometry(input logic [31:0] cols, input logic [31:0] rows,
                               input logic [31:0] radius, input logic [31:0] ox,
                               input logic [31:0] oy);
    write_reg(REG_NUM_COLS, cols);
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    // poke an undecoded index now and then; it must change nothing
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
    settings_used++;
  endtask

  // Hold until every queued word is sent and every answer is back, then settle.
  // Look on the falling edge, once the driver and monitor updates have landed.
  task automatic wait_drained();
    do @(negedge clk);
    while (node_queue.size() != 0 || in_valid || answers_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Driver: present queued node words, predict each one as it is accepted.
  always @(posedge clk) begin : node_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        answers_due.insert(answers_due.size(), predict_node(in_node_index));
        words_sent++;
      end
      // only touch the channel when no word is stuck waiting for ready
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (node_queue.size() != 0) begin
          in_valid      <= 1'b1;
          in_node_index <= node_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: drop ready now and then while a random gap counts down; ready stays high when calm.
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_gap  <= 0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (hold_gap != 0) begin
      hold_gap  <= hold_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_gap  <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    hex_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word arrived with no answer pending", $time);
      end else begin
        want = answers_due.pop_front();
        check_field("index_valid", 32'(want.ok), 32'(out_index_valid));
        check_field("neighbor_count", 32'(want.cnt), 32'(out_neighbor_count));
        check_field("neighbor_a", 32'(want.nb[0]), 32'(out_neighbor_a));
        check_field("neighbor_b", 32'(want.nb[1]), 32'(out_neighbor_b));
        check_field("neighbor_c", 32'(want.nb[2]), 32'(out_neighbor_c));
        check_field("neighbor_d", 32'(want.nb[3]), 32'(out_neighbor_d));
        check_field("neighbor_e", 32'(want.nb[4]), 32'(out_neighbor_e));
        check_field("neighbor_f", 32'(want.nb[5]), 32'(out_neighbor_f));
        check_field("centre_x", want.cx, out_centre_x);
        check_field("centre_y", want.cy, out_centre_y);
        answers_checked++;
        if (!want.ok) out_of_range_seen++;
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d answers pending",
               $time, quiet_cycles, answers_due.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_control
    int reset_set[7]  = '{0, 1, 2, 3, 4, 5, 8191};
    int full_set[13]  = '{0, 1, 63, 64, 65, 126, 127, 190, 4000, 8001, 8030, 8064, 8065};
    int clamp_set[3]  = '{0, 8064, 8065};
    int narrow_set[4] = '{2, 5, 7, 8};
    logic [31:0] cols_raw, rows_raw, radius_raw, ox_raw, oy_raw;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: two-wide packing, corners and the one-node short row.
    foreach (reset_set[k]) node_queue.insert(node_queue.size(), IDX_W'(reset_set[k]));
    wait_drained();

    // Largest packing with top-end radius and origins: every position class but the
    // one-node short row, saturated centres, junk above the column field.
    load_geometry(32'hFFFF_FF40, 32'd127, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    foreach (full_set[k]) node_queue.insert(node_queue.size(), IDX_W'(full_set[k]));
    wait_drained();

    // Columns above range clamp to the maximum; an even row count of 126 is
    // raised to the maximum. Zero radius, most negative origins.
    load_geometry(32'd127, 32'd126, 32'd0, 32'h8000_0000, 32'h8000_0000);
    foreach (clamp_set[k]) node_queue.insert(node_queue.size(), IDX_W'(clamp_set[k]));
    wait_drained();

    // Columns below range clamp up; an even row count is raised.
    load_geometry(32'd0, 32'd4, 32'h0001_0000, 32'd0, 32'd0);
    foreach (narrow_set[k]) node_queue.insert(node_queue.size(), IDX_W'(narrow_set[k]));
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      calm = (phase == PHASES - 1);
      case ($urandom_range(0, 7))
        0:       cols_raw = $urandom_range(0, 1);
        1:       cols_raw = 2;
        2:       cols_raw = MAX_COLS;
        3:       cols_raw = $urandom_range(MAX_COLS + 1, 127);
        4, 5:    cols_raw = $urandom_range(2, 8);
        default: cols_raw = $urandom_range(2, MAX_COLS);
      endcase
      case ($urandom_range(0, 7))
        0:       rows_raw = $urandom_range(0, 2);
        1:       rows_raw = 3;
        2:       rows_raw = $urandom_range(126, 127);
        3, 4:    rows_raw = $urandom_range(3, 15);
        default: rows_raw = $urandom_range(3, MAX_ROWS);
      endcase
      case ($urandom_range(0, 5))
        0:       radius_raw = 0;
        1:       radius_raw = 32'h00FF_FFFF;
        2:       radius_raw = 32'h0001_0000;
        default: radius_raw = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       ox_raw = 32'h7FFF_FFFF;
        1:       ox_raw = 32'h8000_0000;
        2:       ox_raw = 0;
        default: ox_raw = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       oy_raw = 32'h7FFF_FFFF;
        1:       oy_raw = 32'h8000_0000;
        2:       oy_raw = 0;
        default: oy_raw = $urandom();
      endcase
      // random bits above each field are masked by the block
      cols_raw = ($urandom() & ~32'h7F) | (cols_raw & 32'h7F);
      rows_raw = ($urandom() & ~32'h7F) | (rows_raw & 32'h7F);
      load_geometry(cols_raw, rows_raw, radius_raw, ox_raw, oy_raw);

      repeat (HALF_PHASE) node_queue.insert(node_queue.size(), pick_node());
      // hold the sender mid-setting until every answer is back
      wait_drained();
      repeat (HALF_PHASE) node_queue.insert(node_queue.size(), pick_node());
      wait_drained();
    end

    repeat (DRAIN_PAD) @(posedge clk);
    if (answers_due.size() != 0) begin
      mismatches += answers_due.size();
      $display("%0t: %0d answers never arrived", $time, answers_due.size());
    end

    $display("Sent %0d node words and checked %0d answers (%0d out of range) over %0d settings.",
             words_sent, answers_checked, out_of_range_seen, settings_used);
    $display("Clamped sizes, saturated centres and stalls on both channels were exercised.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/hpng_pkg.sv
design/hpng_cfg.sv
design/hpng_div.sv
design/hpng_nbr.sv
design/hpng_geo.sv
design/hex_packing_neighbor_generator_core.sv
tb/sv/tb_top.sv
